// ----- rtl/core/dcbs_pkg.sv -----
package dcbs_pkg;

  localparam int COORD_BITS    = 24;
  localparam int DEPTH_IO_BITS = 16;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CMP_BITS      = COORD_BITS + 1;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int DEPTH_BITS_DEF = 16;

  localparam logic [CFG_BITS-1:0] SRC_WIDTH_RST  = 16'd512;
  localparam logic [CFG_BITS-1:0] SRC_HEIGHT_RST = 16'd424;

  // floor(m / 100) == (m * RECIP_MUL) >> RECIP_SHIFT for all m < 2**16
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = 17'd83887;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 8'd0,
    REG_SOURCE_HEIGHT = 8'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OUTCOME_OK      = 2'd0,
    OUTCOME_OUTSIDE = 2'd1,
    OUTCOME_ZERO    = 2'd2,
    OUTCOME_INCONS  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic outside;
    logic zero;
  } chk_t;

endpackage

// ----- rtl/core/dcbs_front.sv -----
module dcbs_front #(
  parameter int FRAC_BITS  = dcbs_pkg::FRAC_BITS_DEF,
  parameter int DEPTH_BITS = dcbs_pkg::DEPTH_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic signed [dcbs_pkg::COORD_BITS-1:0]   map_x_i,
  input  logic signed [dcbs_pkg::COORD_BITS-1:0]   map_y_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]       depth_lt_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]       depth_rt_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]       depth_lb_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]       depth_rb_i,
  input  logic [dcbs_pkg::CFG_BITS-1:0]            src_width_i,
  input  logic [dcbs_pkg::CFG_BITS-1:0]            src_height_i,
  output dcbs_pkg::chk_t                           chk_o,
  output logic [FRAC_BITS-1:0]                     fx_o,
  output logic [FRAC_BITS-1:0]                     fy_o,
  output logic [3:0][DEPTH_BITS-1:0]               depth_o,
  output logic [DEPTH_BITS-1:0]                    mean_o
);

  localparam int CB = dcbs_pkg::CMP_BITS;
  localparam int TOP = dcbs_pkg::COORD_BITS - 1;

  logic [CB-1:0]               xh, yh;
  logic [3:0][DEPTH_BITS-1:0]  dm;
  logic [DEPTH_BITS+1:0]       sum;
  dcbs_pkg::chk_t              chk_d, chk_q;
  logic [FRAC_BITS-1:0]        fx_q, fy_q;
  logic [3:0][DEPTH_BITS-1:0]  depth_q;
  logic [DEPTH_BITS-1:0]       mean_d, mean_q;

  always_comb begin
    xh = CB'(map_x_i[TOP-1:FRAC_BITS]) + CB'(map_x_i[FRAC_BITS-1:0] != '0);
    yh = CB'(map_y_i[TOP-1:FRAC_BITS]) + CB'(map_y_i[FRAC_BITS-1:0] != '0);
    dm[0] = depth_lt_i[DEPTH_BITS-1:0];
    dm[1] = depth_rt_i[DEPTH_BITS-1:0];
    dm[2] = depth_lb_i[DEPTH_BITS-1:0];
    dm[3] = depth_rb_i[DEPTH_BITS-1:0];
    sum = (DEPTH_BITS+2)'(dm[0]) + (DEPTH_BITS+2)'(dm[1])
        + (DEPTH_BITS+2)'(dm[2]) + (DEPTH_BITS+2)'(dm[3]);
    mean_d = sum[DEPTH_BITS+1:2];
    chk_d.outside = map_x_i[TOP] | map_y_i[TOP]
                  | (xh >= CB'(src_width_i)) | (yh >= CB'(src_height_i));
    chk_d.zero = (dm[0] == '0) | (dm[1] == '0) | (dm[2] == '0) | (dm[3] == '0);
  end

  always_ff @(posedge clk_i) begin
    chk_q   <= chk_d;
    fx_q    <= map_x_i[FRAC_BITS-1:0];
    fy_q    <= map_y_i[FRAC_BITS-1:0];
    depth_q <= dm;
    mean_q  <= mean_d;
  end

  assign chk_o   = chk_q;
  assign fx_o    = fx_q;
  assign fy_o    = fy_q;
  assign depth_o = depth_q;
  assign mean_o  = mean_q;

endmodule

// ----- rtl/core/dcbs_consist.sv -----
module dcbs_consist #(
  parameter int DEPTH_BITS = dcbs_pkg::DEPTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [3:0][DEPTH_BITS-1:0]  depth_i,
  input  logic [DEPTH_BITS-1:0]       mean_i,
  output logic                        ok_o
);

  localparam int PB = DEPTH_BITS + dcbs_pkg::RECIP_SHIFT;

  logic [PB-1:0]               prod_q;
  logic [3:0][DEPTH_BITS-1:0]  diff_d, diff_q;
  logic [DEPTH_BITS-1:0]       thres;
  logic                        ok_d, ok3_q, ok4_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff_d[i] = (depth_i[i] > mean_i) ? depth_i[i] - mean_i : mean_i - depth_i[i];
    end
    thres = prod_q[dcbs_pkg::RECIP_SHIFT +: DEPTH_BITS];
    ok_d = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ok_d = ok_d & (diff_q[i] < thres);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PB'(mean_i) * PB'(dcbs_pkg::RECIP_MUL);
    diff_q <= diff_d;
    ok3_q  <= ok_d;
    ok4_q  <= ok3_q;
  end

  assign ok_o = ok4_q;

endmodule

// ----- rtl/core/dcbs_blend.sv -----
module dcbs_blend #(
  parameter int FRAC_BITS  = dcbs_pkg::FRAC_BITS_DEF,
  parameter int DEPTH_BITS = dcbs_pkg::DEPTH_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic [FRAC_BITS-1:0]                    fx_i,
  input  logic [FRAC_BITS-1:0]                    fy_i,
  input  logic [3:0][DEPTH_BITS-1:0]              depth_i,
  output logic [DEPTH_BITS+2*FRAC_BITS+1-1:0]     top_prod_o,
  output logic [DEPTH_BITS+2*FRAC_BITS+1-1:0]     bot_prod_o
);

  localparam int WB = FRAC_BITS + 1;
  localparam int TB = DEPTH_BITS + FRAC_BITS;
  localparam int PB = DEPTH_BITS + 2 * FRAC_BITS + 1;
  localparam logic [WB-1:0] SCALE = WB'(1) << FRAC_BITS;

  logic [WB-1:0]       ax, bx;
  logic [3:0][TB:0]    part_q;
  logic [WB-1:0]       cy2_q, dy2_q, cy3_q, dy3_q;
  logic [TB-1:0]       top_q, bot_q;
  logic [PB-1:0]       tp_q, bp_q;

  always_comb begin
    ax = WB'(fx_i);
    bx = SCALE - ax;
  end

  always_ff @(posedge clk_i) begin
    part_q[0] <= (TB+1)'(depth_i[0]) * (TB+1)'(bx);
    part_q[1] <= (TB+1)'(depth_i[1]) * (TB+1)'(ax);
    part_q[2] <= (TB+1)'(depth_i[2]) * (TB+1)'(bx);
    part_q[3] <= (TB+1)'(depth_i[3]) * (TB+1)'(ax);
    cy2_q     <= WB'(fy_i);
    dy2_q     <= SCALE - WB'(fy_i);
    top_q     <= TB'(part_q[0] + part_q[1]);
    bot_q     <= TB'(part_q[2] + part_q[3]);
    cy3_q     <= cy2_q;
    dy3_q     <= dy2_q;
    tp_q      <= PB'(top_q) * PB'(dy3_q);
    bp_q      <= PB'(bot_q) * PB'(cy3_q);
  end

  assign top_prod_o = tp_q;
  assign bot_prod_o = bp_q;

endmodule

// ----- rtl/core/depth_consistent_bilinear_sample_top.sv -----
// Depth-consistent bilinear sampler. Pulse start with a source coordinate
// (signed fixed point, FRAC_BITS fraction bits) and the four corner depths;
// exactly one result follows at the pipeline output, marked by a one-cycle
// valid_o pulse, with depth_out_o and outcome_o (0 blended, 1 outside
// source, 2 zero corner, 3 corners inconsistent). busy stays low: the
// five-stage pipeline takes a new item every cycle, so one item per clock
// is sustained. Results cannot be held off; capture them when valid_o is
// high. Source size is written over the cfg port (index 0 width, 1 height,
// other indexes ignored), cfg_ready_o is always high, and writes should be
// made only while no item is in flight.
module depth_consistent_bilinear_sample_top #(
  parameter int FRAC_BITS  = dcbs_pkg::FRAC_BITS_DEF,
  parameter int DEPTH_BITS = dcbs_pkg::DEPTH_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [dcbs_pkg::COORD_BITS-1:0]  map_x_i,
  input  logic signed [dcbs_pkg::COORD_BITS-1:0]  map_y_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]      depth_lt_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]      depth_rt_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]      depth_lb_i,
  input  logic [dcbs_pkg::DEPTH_IO_BITS-1:0]      depth_rb_i,
  output logic                                    valid_o,
  output logic [dcbs_pkg::DEPTH_IO_BITS-1:0]      depth_out_o,
  output logic [1:0]                              outcome_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dcbs_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [dcbs_pkg::CFG_BITS-1:0]           cfg_data_i
);

  localparam int PB = DEPTH_BITS + 2 * FRAC_BITS + 1;

  logic [dcbs_pkg::CFG_BITS-1:0]      width_q, height_q;
  logic [4:0]                         vld_q;
  dcbs_pkg::chk_t                     chk1, chk2_q, chk3_q, chk4_q;
  logic [FRAC_BITS-1:0]               fx, fy;
  logic [3:0][DEPTH_BITS-1:0]         depth;
  logic [DEPTH_BITS-1:0]              mean;
  logic                               ok;
  logic [PB-1:0]                      tp, bp;
  logic [PB-1:0]                      blend;
  logic [dcbs_pkg::DEPTH_IO_BITS-1:0] depth_d, depth_q;
  dcbs_pkg::outcome_e                 outcome_d, outcome_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dcbs_pkg::SRC_WIDTH_RST;
      height_q <= dcbs_pkg::SRC_HEIGHT_RST;
      vld_q    <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start & ~busy};
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          dcbs_pkg::REG_SOURCE_WIDTH:  width_q  <= cfg_data_i;
          dcbs_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  dcbs_front #(
    .FRAC_BITS  (FRAC_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .map_x_i      (map_x_i),
    .map_y_i      (map_y_i),
    .depth_lt_i   (depth_lt_i),
    .depth_rt_i   (depth_rt_i),
    .depth_lb_i   (depth_lb_i),
    .depth_rb_i   (depth_rb_i),
    .src_width_i  (width_q),
    .src_height_i (height_q),
    .chk_o        (chk1),
    .fx_o         (fx),
    .fy_o         (fy),
    .depth_o      (depth),
    .mean_o       (mean)
  );

  dcbs_consist #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_consist (
    .clk_i   (clk_i),
    .depth_i (depth),
    .mean_i  (mean),
    .ok_o    (ok)
  );

  dcbs_blend #(
    .FRAC_BITS  (FRAC_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_blend (
    .clk_i      (clk_i),
    .fx_i       (fx),
    .fy_i       (fy),
    .depth_i    (depth),
    .top_prod_o (tp),
    .bot_prod_o (bp)
  );

  always_comb begin
    blend = tp + bp;
    if (chk4_q.outside) begin
      outcome_d = dcbs_pkg::OUTCOME_OUTSIDE;
      depth_d   = '0;
    end else if (chk4_q.zero) begin
      outcome_d = dcbs_pkg::OUTCOME_ZERO;
      depth_d   = '0;
    end else if (!ok) begin
      outcome_d = dcbs_pkg::OUTCOME_INCONS;
      depth_d   = '0;
    end else begin
      outcome_d = dcbs_pkg::OUTCOME_OK;
      depth_d   = dcbs_pkg::DEPTH_IO_BITS'(blend[2*FRAC_BITS +: DEPTH_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    chk2_q    <= chk1;
    chk3_q    <= chk2_q;
    chk4_q    <= chk3_q;
    depth_q   <= depth_d;
    outcome_q <= outcome_d;
  end

  assign valid_o     = vld_q[4];
  assign depth_out_o = depth_q;
  assign outcome_o   = outcome_q;

endmodule
